>>> rtl/tdal_pkg.sv
// Shared constants for the two-axis dead zone, moving average and low-pass block.
// Holds sample and register widths, reset values and register address codes.
// No dependencies.
`timescale 1ns / 1ps

package tdal_pkg;

    // Sample and coefficient widths
    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned ALPHA_W  = 9;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;

    // Converter midpoint and unity low-pass weight
    localparam logic [SAMPLE_W-1:0] MIDPOINT  = 12'd2048;
    localparam logic [ALPHA_W-1:0]  ALPHA_ONE = 9'd256;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] DEADZONE_RESET = 12'd100;
    localparam logic [ALPHA_W-1:0]  ALPHA_RESET    = 9'd128;

    // Default depth of the averaging window
    localparam int unsigned WINDOW_DEFAULT = 8;

    // Register select codes, taken from address bit 2
    localparam logic REG_DEADZONE = 1'b0;
    localparam logic REG_ALPHA    = 1'b1;

endpackage

>>> rtl/two_axis_deadzone_average_lowpass.sv
// Top level of the two-axis joystick conditioner: dead band, moving average, low-pass.
// Depends on tdal_pkg for widths, reset values and register codes.
`timescale 1ns / 1ps

// Usage
//   Sample channel: x_sample/y_sample with sample_valid; the block drives sample_stall.
//   A request is taken at a rising edge with sample_valid high and sample_stall low.
//   Result channel: x_smoothed/y_smoothed with result_valid; the receiver drives
//   result_stall. A result stays on the ports unchanged while it is stalled.
//   Configuration: APB-style port, deadzone_half_width at byte 0, smoothing_alpha at
//   byte 4 (only paddr[2] is decoded). Write only while no request is in flight.
// Timing
//   Three register stages: running window sum, mean by reciprocal multiply, and the
//   low-pass multiply-add. A taken request moves from the first stage register through
//   the second into the result register, which drives the ports. Throughput is one
//   request per cycle unless the receiver stalls; the window sum and the low-pass
//   feedback each close through one register; the window is a fixed-oldest-tap shift line.
//   When the receiver stalls, the stages fill up and sample_stall rises once the first
//   stage holds a request that cannot move on; no request is lost or repeated.
// Reset
//   rst_n clears the windows, the running sums, the low-pass history, all valid flags,
//   and loads the register reset values. No clearing pass is needed.
module two_axis_deadzone_average_lowpass #(
    parameter int unsigned WINDOW = tdal_pkg::WINDOW_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // sample channel
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  logic [tdal_pkg::SAMPLE_W-1:0]      x_sample,
    input  logic [tdal_pkg::SAMPLE_W-1:0]      y_sample,
    // result channel
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [tdal_pkg::SAMPLE_W-1:0]      x_smoothed,
    output logic [tdal_pkg::SAMPLE_W-1:0]      y_smoothed,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tdal_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tdal_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tdal_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    localparam int unsigned SW          = tdal_pkg::SAMPLE_W;
    localparam int unsigned AW          = tdal_pkg::ALPHA_W;
    localparam int unsigned LOG_W       = $clog2(WINDOW);
    localparam int unsigned SUM_W       = SW + LOG_W;
    localparam int unsigned PROD_W      = 2 * SUM_W + 1;
    // Exact reciprocal: floor(sum * RECIP >> RECIP_SHIFT) == sum / WINDOW for any sum
    localparam int unsigned RECIP_SHIFT = SUM_W + LOG_W;
    localparam logic [SUM_W:0] RECIP =
        (SUM_W+1)'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
    localparam int unsigned LP_W        = AW + SW + 2;
    localparam int unsigned NUM_AXES    = 2;

    // Configuration registers
    logic [SW-1:0]  deadzone_reg;
    logic [AW-1:0]  alpha_reg;

    // Window shift lines and running sums, one per axis
    logic [SW-1:0]    line_reg [NUM_AXES][WINDOW];
    logic [SUM_W-1:0] sum_reg  [NUM_AXES];
    logic [SUM_W-1:0] sum_next [NUM_AXES];

    // Pipeline stages
    logic             s1_valid_reg;
    logic [SUM_W-1:0] s1_sum_reg  [NUM_AXES];
    logic             s2_valid_reg;
    logic [SW-1:0]    s2_mean_reg [NUM_AXES];
    logic [SW-1:0]    s2_mean_next[NUM_AXES];
    logic             s3_valid_reg;
    logic [SW-1:0]    smooth_reg  [NUM_AXES];
    logic [SW-1:0]    smooth_next [NUM_AXES];

    logic [SW-1:0]    sample_in   [NUM_AXES];
    logic [SW-1:0]    banded      [NUM_AXES];
    logic [AW-1:0]    alpha_eff;

    logic sample_take;
    logic s3_ready;
    logic s2_ready;
    logic s1_ready;
    logic s2_load;
    logic s3_load;
    logic cfg_write;

    assign sample_in[0] = x_sample;
    assign sample_in[1] = y_sample;

    // Handshake: each stage moves when the one after it has room
    assign s3_ready     = !s3_valid_reg || !result_stall;
    assign s3_load      = s2_valid_reg && s3_ready;
    assign s2_ready     = !s2_valid_reg || s3_ready;
    assign s2_load      = s1_valid_reg && s2_ready;
    assign s1_ready     = !s1_valid_reg || s2_ready;
    assign sample_stall = !s1_ready;
    assign sample_take  = sample_valid && s1_ready;

    // Dead band and running sum update
    always_comb
    begin
        logic [SW:0] upper;
        logic [SW:0] sum_st;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            // 2048 - t < s  is  s + t > 2048;  s < 2048 + t
            sum_st = {1'b0, sample_in[i]} + {1'b0, deadzone_reg};
            upper  = {1'b0, tdal_pkg::MIDPOINT} + {1'b0, deadzone_reg};
            if ((sum_st > {1'b0, tdal_pkg::MIDPOINT}) && ({1'b0, sample_in[i]} < upper))
                banded[i] = tdal_pkg::MIDPOINT;
            else
                banded[i] = sample_in[i];
            sum_next[i] = sum_reg[i] + SUM_W'(banded[i]) - SUM_W'(line_reg[i][WINDOW-1]);
        end
    end

    // Mean by multiplying with the exact reciprocal of the window depth
    always_comb
    begin
        logic [PROD_W-1:0] quot_prod;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            quot_prod       = PROD_W'(s1_sum_reg[i]) * PROD_W'(RECIP);
            s2_mean_next[i] = quot_prod[RECIP_SHIFT +: SW];
        end
    end

    // Low-pass: last + alpha * (mean - last), weight clamped to one
    assign alpha_eff = (alpha_reg > tdal_pkg::ALPHA_ONE) ? tdal_pkg::ALPHA_ONE : alpha_reg;

    always_comb
    begin
        logic signed [SW:0]     diff;
        logic signed [LP_W-1:0] lp_prod;
        logic signed [LP_W-1:0] lp_acc;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            diff    = $signed({1'b0, s2_mean_reg[i]}) - $signed({1'b0, smooth_reg[i]});
            lp_prod = LP_W'($signed({1'b0, alpha_eff})) * LP_W'(diff);
            lp_acc  = $signed({{(LP_W-SW-8){1'b0}}, smooth_reg[i], 8'b0}) + lp_prod;
            smooth_next[i] = lp_acc[8 +: SW];
        end
    end

    // Advance window lines and running sums on each taken request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                sum_reg[i] <= '0;
                for (int k = 0; k < WINDOW; k++)
                    line_reg[i][k] <= '0;
            end
        end
        else if (sample_take)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                sum_reg[i]     <= sum_next[i];
                line_reg[i][0] <= banded[i];
                for (int k = 1; k < WINDOW; k++)
                    line_reg[i][k] <= line_reg[i][k-1];
            end
        end
    end

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= sample_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            if (sample_take)
                s1_sum_reg[i] <= sum_next[i];
            if (s2_load)
                s2_mean_reg[i] <= s2_mean_next[i];
        end
    end

    // Result register doubles as the low-pass history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
                smooth_reg[i] <= '0;
        end
        else if (s3_load)
        begin
            for (int i = 0; i < NUM_AXES; i++)
                smooth_reg[i] <= smooth_next[i];
        end
    end

    assign result_valid = s3_valid_reg;
    assign x_smoothed   = smooth_reg[0];
    assign y_smoothed   = smooth_reg[1];

    // Configuration writes
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg <= tdal_pkg::DEADZONE_RESET;
            alpha_reg    <= tdal_pkg::ALPHA_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                tdal_pkg::REG_DEADZONE: deadzone_reg <= pwdata[SW-1:0];
                tdal_pkg::REG_ALPHA:    alpha_reg    <= pwdata[AW-1:0];
                default:                deadzone_reg <= deadzone_reg;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (paddr[2])
            tdal_pkg::REG_DEADZONE: prdata = {(tdal_pkg::APB_DATA_W-SW)'(0), deadzone_reg};
            tdal_pkg::REG_ALPHA:    prdata = {(tdal_pkg::APB_DATA_W-AW)'(0), alpha_reg};
            default:                prdata = '0;
        endcase
    end

    // Stall only when the first stage is full and cannot drain
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && result_stall))
        else $error("sample_stall raised while the pipeline had room");

    // A taken request occupies the first stage on the next cycle
    a_take_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        sample_take |=> s1_valid_reg)
        else $error("taken request missing from first stage");

    // A delivered result with nothing behind it leaves the output empty
    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !s2_valid_reg) |=> !result_valid)
        else $error("result repeated after delivery");

    // A stalled result keeps the low-pass history unchanged
    a_history_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> ($stable(smooth_reg[0]) && $stable(smooth_reg[1])))
        else $error("low-pass history moved under stall");

endmodule
